[hw/rtl/bwfc_pkg.sv]
// Package for the buffer watermark flow control block.
// Holds opcode and grant-mode codes, register indexes and fixed field widths.
// No dependencies.
package bwfc_pkg;

  localparam int OPCODE_W  = 2;
  localparam int AMOUNT_W  = 32;
  localparam int RES_W     = 18;
  localparam int OCC_OUT_W = 40;
  localparam int CFG_W     = 32;
  localparam int CFG_AW    = 3;

  localparam int unsigned RES_MAX = (1 << RES_W) - 1;

  typedef enum logic [OPCODE_W-1:0] {
    OP_ADD     = 2'd0,
    OP_DRAIN   = 2'd1,
    OP_RESERVE = 2'd2,
    OP_RECHECK = 2'd3
  } opcode_t;

  // How the reserve grant of an item is formed downstream
  typedef enum logic [1:0] {
    GM_NONE  = 2'd0,
    GM_FULL  = 2'd1,
    GM_SLICE = 2'd2,
    GM_CALC  = 2'd3
  } grant_mode_t;

  localparam logic CFG_HIGH = 1'b0;
  localparam logic CFG_MULT = 1'b1;

  typedef struct packed {
    logic                 above;
    logic                 below;
    logic                 ovf;
    grant_mode_t          mode;
    logic [OCC_OUT_W-1:0] occ;
  } res_info_t;

endpackage

[hw/rtl/bwfc_if.sv]
// Valid/ready channel interfaces for the buffer watermark flow control block.
// Depends on bwfc_pkg for field widths.
interface bwfc_in_if;
  logic                           valid;
  logic                           ready;
  logic [bwfc_pkg::OPCODE_W-1:0]  opcode;
  logic [bwfc_pkg::AMOUNT_W-1:0]  amount;

  modport source (output valid, output opcode, output amount, input ready);
  modport sink   (input valid, input opcode, input amount, output ready);
endinterface

interface bwfc_out_if;
  logic                           valid;
  logic                           ready;
  logic                           went_above_high;
  logic                           went_below_low;
  logic                           went_above_overflow;
  logic [bwfc_pkg::RES_W-1:0]     reserve_bytes;
  logic [bwfc_pkg::OCC_OUT_W-1:0] occupancy;

  modport source (output valid, output went_above_high, output went_below_low,
                  output went_above_overflow, output reserve_bytes, output occupancy,
                  input ready);
  modport sink   (input valid, input went_above_high, input went_below_low,
                  input went_above_overflow, input reserve_bytes, input occupancy,
                  output ready);
endinterface

[hw/rtl/buffer_watermark_flow_control.sv]
// 4 register stages counting the result register; throughput one request per cycle
// while the output channel is not stalled by out_ch.ready.
// Occupancy and the high/overflow marks update in the first stage, so requests run
// back to back; the next two stages round the reserve grant with two multipliers.
// Any stage advances when the one after it is empty or advancing.
// Synchronous active-low reset clears occupancy, marks, configuration registers and stage valids.
// Depends on bwfc_pkg and bwfc_if.
module buffer_watermark_flow_control #(
  parameter int READ_RESERVE_BYTES = 131072,
  parameter int SLICE_BYTES        = 16384,
  parameter int OCCUPANCY_BITS     = 40
) (
  input  logic                        clk,
  input  logic                        rst_n,
  bwfc_in_if.sink                     in_ch,
  bwfc_out_if.source                  out_ch,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [bwfc_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [bwfc_pkg::CFG_W-1:0]  cfg_pwdata,
  output logic [bwfc_pkg::CFG_W-1:0]  cfg_prdata,
  output logic                        cfg_pready
);
  import bwfc_pkg::*;

  localparam int OB = OCCUPANCY_BITS;
  localparam int XW = $clog2(READ_RESERVE_BYTES + SLICE_BYTES + 1);
  localparam longint unsigned RECIP = (64'd1 << XW) / SLICE_BYTES;
  localparam int unsigned RRB_CLIP =
    (READ_RESERVE_BYTES > RES_MAX) ? RES_MAX : READ_RESERVE_BYTES;
  localparam int unsigned SLC_CLIP = (SLICE_BYTES > RES_MAX) ? RES_MAX : SLICE_BYTES;

  // ---------------- configuration ----------------
  logic [CFG_W-1:0] high_r, mult_r, lvl_r, lvl_nxt;
  logic             lvl_en_r, lvl_en_nxt;
  logic             cfg_wr;
  logic [CFG_W-1:0] mul_a, mul_b, mult_new;
  logic [2*CFG_W-1:0] cfg_prod;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[2] == CFG_MULT) ? mult_r : high_r;

  // Form the overflow level at write time so it is ready with the register
  always_comb begin
    mul_a    = (cfg_paddr[2] == CFG_HIGH) ? cfg_pwdata : high_r;
    mul_b    = (cfg_paddr[2] == CFG_MULT) ? cfg_pwdata : mult_r;
    mult_new = mul_b;
    cfg_prod = (2*CFG_W)'(mul_a) * (2*CFG_W)'(mul_b);
    lvl_nxt  = cfg_prod[CFG_W-1:0];
    lvl_en_nxt = (mult_new != '0) && (cfg_prod[2*CFG_W-1:CFG_W] == '0) &&
                 (cfg_prod[CFG_W-1:0] != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_r   <= '0;
      mult_r   <= '0;
      lvl_r    <= '0;
      lvl_en_r <= 1'b0;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == CFG_HIGH) begin
        high_r <= cfg_pwdata;
      end else begin
        mult_r <= cfg_pwdata;
      end
      lvl_r    <= lvl_nxt;
      lvl_en_r <= lvl_en_nxt;
    end
  end

  // ---------------- pipeline control ----------------
  logic p1_v_r, p2_v_r, p3_v_r, out_v_r;
  logic en1, en2, en3, en_o, acc;

  assign en_o = !out_v_r || out_ch.ready;
  assign en3  = !p3_v_r || en_o;
  assign en2  = !p2_v_r || en3;
  assign en1  = !p1_v_r || en2;
  assign in_ch.ready = en1;
  assign acc  = in_ch.valid && en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r  <= 1'b0;
      p2_v_r  <= 1'b0;
      p3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (en1) p1_v_r  <= in_ch.valid;
      if (en2) p2_v_r  <= p1_v_r;
      if (en3) p3_v_r  <= p2_v_r;
      if (en_o) out_v_r <= p3_v_r;
    end
  end

  // ---------------- stage 1: occupancy and marks ----------------
  logic [OB-1:0] occ_r, occ_nxt;
  logic          ah_r, ah_nxt, ov_r, ov_nxt;
  logic [OB:0]   sum;
  logic [OB-1:0] hw_ext, hw_half, lvl_ext, amt_ext;
  logic          do_high, do_low, cond_h, set_ah, set_ov, clr_ah, ah_mid;
  logic [CFG_W-1:0] room;
  grant_mode_t   mode;
  logic [XW-1:0] x_nxt;
  res_info_t     info_nxt;

  always_comb begin
    hw_ext  = OB'(high_r);
    hw_half = OB'(high_r >> 1);
    lvl_ext = OB'(lvl_r);
    amt_ext = OB'(in_ch.amount);
    sum     = {1'b0, occ_r} + (OB+1)'(in_ch.amount);
    occ_nxt = occ_r;
    do_high = 1'b0;
    do_low  = 1'b0;
    mode    = GM_NONE;
    room    = '0;
    x_nxt   = '0;
    case (opcode_t'(in_ch.opcode))
      OP_ADD: begin
        occ_nxt = sum[OB] ? '1 : sum[OB-1:0];
        do_high = 1'b1;
      end
      OP_DRAIN: begin
        occ_nxt = (amt_ext > occ_r) ? '0 : occ_r - amt_ext;
        do_low  = 1'b1;
      end
      OP_RESERVE: begin
        if (high_r == '0 || READ_RESERVE_BYTES == 0) begin
          mode = GM_FULL;
        end else if (occ_r >= hw_ext) begin
          mode = GM_SLICE;
        end else begin
          room = high_r - occ_r[CFG_W-1:0];
          if (room >= CFG_W'(READ_RESERVE_BYTES)) begin
            mode = GM_FULL;
          end else begin
            mode  = GM_CALC;
            x_nxt = XW'(room) + XW'(SLICE_BYTES - 1);
          end
        end
      end
      OP_RECHECK: begin
        do_high = 1'b1;
        do_low  = 1'b1;
      end
      default: begin
        occ_nxt = occ_r;
      end
    endcase

    // High check runs before the low check, on the updated occupancy
    cond_h = do_high && (high_r != '0) && (occ_nxt > hw_ext);
    set_ah = cond_h && !ah_r;
    ah_mid = ah_r || cond_h;
    set_ov = cond_h && lvl_en_r && !ov_r && (occ_nxt > lvl_ext);
    clr_ah = do_low && ah_mid && ((high_r == '0) || (occ_nxt <= hw_half));
    ah_nxt = ah_mid && !clr_ah;
    ov_nxt = ov_r || set_ov;

    info_nxt.above = set_ah;
    info_nxt.below = clr_ah;
    info_nxt.ovf   = set_ov;
    info_nxt.mode  = mode;
    info_nxt.occ   = OCC_OUT_W'(occ_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
      ah_r  <= 1'b0;
      ov_r  <= 1'b0;
    end else if (acc) begin
      occ_r <= occ_nxt;
      ah_r  <= ah_nxt;
      ov_r  <= ov_nxt;
    end
  end

  res_info_t     p1_info_r, p2_info_r, p3_info_r;
  logic [XW-1:0] p1_x_r, p2_x_r, p3_x_r;
  logic [XW-1:0] p2_q_r, p3_pq_r;

  always_ff @(posedge clk) begin
    if (en1) begin
      p1_info_r <= info_nxt;
      p1_x_r    <= x_nxt;
    end
  end

  // ---------------- stage 2: quotient estimate ----------------
  logic [2*XW:0] xm;
  assign xm = (2*XW+1)'(p1_x_r) * (2*XW+1)'(RECIP);

  always_ff @(posedge clk) begin
    if (en2) begin
      p2_info_r <= p1_info_r;
      p2_x_r    <= p1_x_r;
      p2_q_r    <= xm[XW +: XW];
    end
  end

  // ---------------- stage 3: back to bytes ----------------
  logic [2*XW-1:0] qs;
  assign qs = (2*XW)'(p2_q_r) * (2*XW)'(SLICE_BYTES);

  always_ff @(posedge clk) begin
    if (en3) begin
      p3_info_r <= p2_info_r;
      p3_x_r    <= p2_x_r;
      p3_pq_r   <= qs[XW-1:0];
    end
  end

  // ---------------- output stage: correct and clip ----------------
  logic [XW-1:0]    rem, len;
  logic [CFG_W-1:0] len_w;
  logic [RES_W-1:0] grant;

  always_comb begin
    // Estimate is low by at most one slice; bump when the remainder shows it
    rem   = p3_x_r - p3_pq_r;
    len   = ((XW+1)'(rem) >= (XW+1)'(SLICE_BYTES)) ? p3_pq_r + XW'(SLICE_BYTES) : p3_pq_r;
    len_w = CFG_W'(len);
    if (len_w > CFG_W'(READ_RESERVE_BYTES)) len_w = CFG_W'(READ_RESERVE_BYTES);
    if (len_w > CFG_W'(RES_MAX)) len_w = CFG_W'(RES_MAX);
    case (p3_info_r.mode)
      GM_NONE:  grant = '0;
      GM_FULL:  grant = RES_W'(RRB_CLIP);
      GM_SLICE: grant = RES_W'(SLC_CLIP);
      GM_CALC:  grant = len_w[RES_W-1:0];
      default:  grant = '0;
    endcase
  end

  res_info_t        out_info_r;
  logic [RES_W-1:0] out_grant_r;

  always_ff @(posedge clk) begin
    if (en_o) begin
      out_info_r  <= p3_info_r;
      out_grant_r <= grant;
    end
  end

  assign out_ch.valid               = out_v_r;
  assign out_ch.went_above_high     = out_info_r.above;
  assign out_ch.went_below_low      = out_info_r.below;
  assign out_ch.went_above_overflow = out_info_r.ovf;
  assign out_ch.reserve_bytes       = out_grant_r;
  assign out_ch.occupancy           = out_info_r.occ;

  // ---------------- assertions ----------------
  a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |=> ov_r)
    else $error("overflow mark cleared without reset");

  a_occ_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !acc |=> $stable(occ_r))
    else $error("occupancy changed without an accepted request");

  a_no_cross_both: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> !(out_info_r.above && out_info_r.below))
    else $error("result both latched and cleared the high mark");

  a_grant_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && (out_grant_r != '0)) |->
      !(out_info_r.above || out_info_r.below || out_info_r.ovf))
    else $error("reserve result carries watermark flags");

  a_ovf_needs_high: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && set_ov) |=> ah_r)
    else $error("overflow latched without the high mark");

endmodule
